// ===== rtl/core/pcr_pkg.sv =====
// pcr_pkg: shared widths, point and queue types for the collinear point reducer.
// No dependencies; imported by every module under rtl/core.
package pcr_pkg;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int TOL_W    = 16;
  localparam int TOLSQ_W  = 2 * TOL_W;
  localparam int CMP_W    = (SUM_W > TOLSQ_W) ? SUM_W : TOLSQ_W;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } point_t;

  typedef struct packed {
    logic   push0;
    logic   push1;
    point_t p0;
    point_t p1;
  } q_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              room;
    logic              nonempty;
  } q_status_t;

endpackage

// ===== rtl/core/polyline_collinear_reduce_unit.sv =====
// polyline_collinear_reduce_unit: top level of the collinear point reducer.
// Depends on pcr_pkg, pcr_front, pcr_queue, pcr_back.
//
// Usage:
//   Input channel (in_valid/in_ready, in_x, in_y, last_point) takes one point
//   per request; last_point closes the polyline. Output channel (out_valid/
//   out_ready, out_x, out_y, out_last) delivers kept points, out_last on the
//   final one of each polyline.
//   cfg_we/cfg_data write the distance tolerance; write only while idle. The
//   squared tolerance is used from the following cycle.
//   Throughput: one point per cycle while in_ready is high. Each point is
//   classified in the cycle it is accepted (two subtracts, two 17x17
//   multiplies, add or subtract, compare with the registered tolerance
//   squared) and yields zero, one or two kept points. Accepted points pass
//   through the queue memory and then the output register. A four-entry
//   queue sits between classifier and output register; in_ready is high
//   while at least two entries are free, so a stalled receiver fills the
//   queue and then holds off input; two results of a point leave one by one.
//   Reset: synchronous; clears the polyline phase, the tolerance, the queue
//   and the output valid flag.
module polyline_collinear_reduce_unit import pcr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [TOL_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic                      last_point,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic                      out_last
);

  q_push_t   q_push;
  q_status_t q_status;
  point_t    head;
  logic      pop;

  pcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_x       (in_x),
    .in_y       (in_y),
    .last_point (last_point),
    .q_status   (q_status),
    .q_push     (q_push)
  );

  pcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  pcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_status.nonempty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_last   (out_last)
  );

`ifndef NO_ASSERTIONS
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= QCNT_W'(QDEPTH))
    else $error("queue over depth");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (q_status.count <= QCNT_W'(QDEPTH - 2)))
    else $error("input taken without room for two points");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    q_push.push1 |-> q_push.push0)
    else $error("second push without first");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_status.count != '0))
    else $error("pop from empty queue");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== rtl/core/pcr_front.sv =====
// pcr_front: accepts input points, holds anchor/direction/pending state and
// decides which points are kept. Pushes up to two kept points per request.
// Depends on pcr_pkg.
module pcr_front import pcr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [TOL_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic                      last_point,
  input  q_status_t                 q_status,
  output q_push_t                   q_push
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEARCH = 2'd1,
    PH_TRACK  = 2'd2
  } phase_t;

  phase_t             phase, phase_next;
  logic [TOLSQ_W-1:0] tol_sq;
  logic [COORD_W-1:0] anchor_x, anchor_y, anchor_x_next, anchor_y_next;
  logic [COORD_W-1:0] pending_x, pending_y, pending_x_next, pending_y_next;
  logic [DIFF_W-1:0]  dir_x, dir_y, dir_x_next, dir_y_next;

  logic                     accept, track;
  logic signed [DIFF_W-1:0] tx, ty, opa1, opa2;
  logic signed [PROD_W-1:0] m1, m2;
  logic signed [SUM_W-1:0]  m1_ext, m2_ext, sum;
  logic [SUM_W-1:0]         mag;
  logic                     hit;
  point_t                   cur_pt, pend_pt, anch_pt;

  assign in_ready = q_status.room;
  assign accept   = in_valid && in_ready;
  assign track    = (phase == PH_TRACK);

  // t = point - anchor; same operands serve squared distance and cross product
  assign tx   = {in_x[COORD_W-1], in_x} - {anchor_x[COORD_W-1], anchor_x};
  assign ty   = {in_y[COORD_W-1], in_y} - {anchor_y[COORD_W-1], anchor_y};
  assign opa1 = track ? dir_x : ty;
  assign opa2 = track ? dir_y : tx;
  assign m1   = opa1 * ty;
  assign m2   = opa2 * tx;

  assign m1_ext = {m1[PROD_W-1], m1};
  assign m2_ext = {m2[PROD_W-1], m2};
  assign sum    = track ? (m1_ext - m2_ext) : (m1_ext + m2_ext);
  assign mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign hit    = CMP_W'(mag) >= CMP_W'(tol_sq);

  assign cur_pt  = '{x: in_x,      y: in_y,      last: 1'b1};
  assign pend_pt = '{x: pending_x, y: pending_y, last: 1'b0};
  assign anch_pt = '{x: anchor_x,  y: anchor_y,  last: 1'b0};

  always_comb begin
    phase_next     = phase;
    anchor_x_next  = anchor_x;
    anchor_y_next  = anchor_y;
    pending_x_next = pending_x;
    pending_y_next = pending_y;
    dir_x_next     = dir_x;
    dir_y_next     = dir_y;
    q_push         = '0;
    if (accept) begin
      case (phase)
        PH_SEARCH: begin
          if (!hit) begin
            if (last_point) begin
              q_push.push0 = 1'b1;
              q_push.p0    = '{x: anchor_x, y: anchor_y, last: 1'b1};
              phase_next   = PH_IDLE;
            end
          end else begin
            q_push.push0 = 1'b1;
            q_push.p0    = anch_pt;
            if (last_point) begin
              q_push.push1 = 1'b1;
              q_push.p1    = cur_pt;
              phase_next   = PH_IDLE;
            end else begin
              dir_x_next     = tx;
              dir_y_next     = ty;
              pending_x_next = in_x;
              pending_y_next = in_y;
              phase_next     = PH_TRACK;
            end
          end
        end
        PH_TRACK: begin
          if (hit) begin
            q_push.push0  = 1'b1;
            q_push.p0     = pend_pt;
            anchor_x_next = pending_x;
            anchor_y_next = pending_y;
            dir_x_next    = {in_x[COORD_W-1], in_x} - {pending_x[COORD_W-1], pending_x};
            dir_y_next    = {in_y[COORD_W-1], in_y} - {pending_y[COORD_W-1], pending_y};
          end
          pending_x_next = in_x;
          pending_y_next = in_y;
          if (last_point) begin
            if (hit) begin
              q_push.push1 = 1'b1;
              q_push.p1    = cur_pt;
            end else begin
              q_push.push0 = 1'b1;
              q_push.p0    = cur_pt;
            end
            phase_next = PH_IDLE;
          end
        end
        default: begin
          if (last_point) begin
            q_push.push0 = 1'b1;
            q_push.p0    = cur_pt;
            phase_next   = PH_IDLE;
          end else begin
            anchor_x_next = in_x;
            anchor_y_next = in_y;
            phase_next    = PH_SEARCH;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      tol_sq <= '0;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        tol_sq <= TOLSQ_W'(cfg_data) * TOLSQ_W'(cfg_data);
      end
    end
    anchor_x  <= anchor_x_next;
    anchor_y  <= anchor_y_next;
    pending_x <= pending_x_next;
    pending_y <= pending_y_next;
    dir_x     <= dir_x_next;
    dir_y     <= dir_y_next;
  end

endmodule

// ===== rtl/core/pcr_queue.sv =====
// pcr_queue: small queue of kept points between front and back; two writes,
// one read per cycle. Depends on pcr_pkg.
module pcr_queue import pcr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_push_t   q_push,
  input  logic      pop,
  output point_t    head,
  output q_status_t q_status
);

  point_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic [QPTR_W-1:0] wr_ptr1;
  logic              do_pop;

  assign wr_ptr1 = wr_ptr + QPTR_W'(1);
  assign do_pop  = pop && (count != '0);
  assign head    = mem[rd_ptr];

  assign count_next = count + QCNT_W'(q_push.push0) + QCNT_W'(q_push.push1)
                      - QCNT_W'(do_pop);

  assign q_status.count    = count;
  assign q_status.room     = (count <= QCNT_W'(QDEPTH - 2));
  assign q_status.nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(q_push.push0) + QPTR_W'(q_push.push1);
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
    if (q_push.push0) begin
      mem[wr_ptr] <= q_push.p0;
    end
    if (q_push.push1) begin
      mem[wr_ptr1] <= q_push.p1;
    end
  end

endmodule

// ===== rtl/core/pcr_back.sv =====
// pcr_back: output register; drains the point queue onto the result channel.
// Depends on pcr_pkg.
module pcr_back import pcr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_nonempty,
  input  point_t                    head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic                      out_last
);

  assign pop = q_nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (pop) begin
      out_x    <= head.x;
      out_y    <= head.y;
      out_last <= head.last;
    end
  end

endmodule
